// ===== sv/multi_priority_event_queue_assert.svh =====
// Assertion macros shared by the event queue RTL.
`ifndef MULTI_PRIORITY_EVENT_QUEUE_ASSERT_SVH
`define MULTI_PRIORITY_EVENT_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPEQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MPEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/mpeq_pkg.sv =====
`default_nettype none

package mpeq_pkg;

    localparam int NUM_LEVELS_DEF = 3;
    localparam int FIFO_DEPTH_DEF = 16;

    localparam int PAYLOAD_W = 64;
    localparam int TIME_W    = 32;
    localparam int PRIO_W    = 8;
    localparam int LEVEL_W   = 3;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    // One stored entry of the shared slot memory.
    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic [TIME_W-1:0]    stamp;
        logic [TIME_W-1:0]    lifetime;
    } t_slot;

    typedef struct packed {
        logic                 push_accepted;
        logic                 item_valid;
        logic                 item_expired;
        logic [PAYLOAD_W-1:0] item_payload;
        logic [LEVEL_W-1:0]   item_level;
        logic                 all_empty;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/multi_priority_event_queue.sv =====
// A push, clear or no-op result is registered in the cycle after its input transfer;
// a pop that finds an entry passes the slot memory read register, then the output register.
// Throughput: one command per cycle for push/clear while the output is not stalled; a pop
// that finds an entry holds off input until its single-port slot memory read is done; an empty pop does not.
// Reset (i_rst_n, synchronous, active low) empties every FIFO and the output register;
// the slot memory is not cleared, since only written entries are ever read.
`default_nettype none

`include "multi_priority_event_queue_assert.svh"

module multi_priority_event_queue
    import mpeq_pkg::*;
#(
    parameter int NUM_LEVELS = NUM_LEVELS_DEF,
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Input command stream.
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // tdata, lowest bit up: priority_req[7:0], time_to_live[31:0], payload[63:0], now_ms[31:0]
    input  wire logic [135:0] i_s_axis_tdata,
    // tuser: command[1:0]
    input  wire logic [1:0]   i_s_axis_tuser,
    // Result stream.
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // tdata, lowest bit up: push_accepted, item_expired, item_payload[63:0],
    // item_level[2:0], all_empty, two zero pad bits
    output logic [71:0]       o_m_axis_tdata,
    // tuser: item_valid
    output logic              o_m_axis_tuser
);

    // Derived widths: level select, ring pointer, fill count, slot address.
    localparam int LW    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int PW    = $clog2(FIFO_DEPTH);
    localparam int CW    = $clog2(FIFO_DEPTH + 1);
    localparam int SLOTS = NUM_LEVELS * FIFO_DEPTH;
    localparam int AW    = $clog2(SLOTS);

    // Two-state sequencer: idle accepts commands, read waits for the slot memory.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    t_state r_state, n_state;

    // Per-level ring pointers and fill counts live in flip-flops; the entries
    // themselves live in the shared slot memory.
    logic [PW-1:0] r_head [NUM_LEVELS];
    logic [PW-1:0] r_tail [NUM_LEVELS];
    logic [CW-1:0] r_fill [NUM_LEVELS];
    logic [PW-1:0] n_head [NUM_LEVELS];
    logic [PW-1:0] n_tail [NUM_LEVELS];
    logic [CW-1:0] n_fill [NUM_LEVELS];

    t_result r_out, n_out;
    logic    r_out_valid, n_out_valid;

    // Context of a pop that is waiting for its memory read.
    logic [TIME_W-1:0] r_now;
    logic [LW-1:0]     r_pop_lv;
    logic              r_pop_empty;

    // Unpacked input fields.
    t_cmd                 w_cmd;
    logic [PRIO_W-1:0]    w_prio;
    logic [TIME_W-1:0]    w_ttl;
    logic [PAYLOAD_W-1:0] w_payload;
    logic [TIME_W-1:0]    w_now;

    logic          w_accept;
    logic [LW-1:0] w_push_lv;
    logic          w_pop_found;
    logic [LW-1:0] w_pop_lv;
    logic          w_n_empty;
    logic          w_fill_over;

    logic          w_ram_wr;
    logic          w_ram_rd;
    logic [AW-1:0] w_ram_addr;
    t_slot         w_ram_wdata;
    t_slot         w_ram_rdata;

    logic [TIME_W-1:0] w_limit;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] pos);
        ring_next = (pos == PW'(FIFO_DEPTH - 1)) ? '0 : pos + 1'b1;
    endfunction

    assign w_cmd     = t_cmd'(i_s_axis_tuser);
    assign w_prio    = i_s_axis_tdata[7:0];
    assign w_ttl     = i_s_axis_tdata[39:8];
    assign w_payload = i_s_axis_tdata[103:40];
    assign w_now     = i_s_axis_tdata[135:104];

    // A new command is taken only while idle and once the output register is
    // free or being drained in this same cycle.
    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Priorities above the top level fold onto the top level.
    assign w_push_lv = (w_prio >= PRIO_W'(NUM_LEVELS)) ? LW'(NUM_LEVELS - 1) : w_prio[LW-1:0];

    // Highest non-empty level wins the pop.
    always_comb begin
        w_pop_found = 1'b0;
        w_pop_lv    = '0;
        for (int k = 0; k < NUM_LEVELS; k++) begin
            if (r_fill[k] != '0) begin
                w_pop_found = 1'b1;
                w_pop_lv    = LW'(k);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        w_ram_wr    = 1'b0;
        w_ram_rd    = 1'b0;
        w_ram_addr  = '0;
        w_ram_wdata = '{payload: w_payload, stamp: w_now, lifetime: w_ttl};

        if (w_accept) begin
            unique case (w_cmd)
                CMD_PUSH: begin
                    w_ram_addr = AW'(w_push_lv) * AW'(FIFO_DEPTH) + AW'(r_tail[w_push_lv]);
                    if (r_fill[w_push_lv] != CW'(FIFO_DEPTH)) begin
                        w_ram_wr            = 1'b1;
                        n_tail[w_push_lv]   = ring_next(r_tail[w_push_lv]);
                        n_fill[w_push_lv]   = r_fill[w_push_lv] + 1'b1;
                    end
                end
                CMD_POP: begin
                    w_ram_addr = AW'(w_pop_lv) * AW'(FIFO_DEPTH) + AW'(r_head[w_pop_lv]);
                    if (w_pop_found) begin
                        w_ram_rd           = 1'b1;
                        n_head[w_pop_lv]   = ring_next(r_head[w_pop_lv]);
                        n_fill[w_pop_lv]   = r_fill[w_pop_lv] - 1'b1;
                        n_state            = ST_READ;
                    end
                end
                CMD_CLEAR: begin
                    for (int k = 0; k < NUM_LEVELS; k++) begin
                        n_head[k] = '0;
                        n_tail[k] = '0;
                        n_fill[k] = '0;
                    end
                end
                default: begin
                    // The fourth command code does nothing but report emptiness.
                end
            endcase
        end else if (r_state == ST_READ) begin
            n_state = ST_IDLE;
        end
    end

    always_comb begin
        w_n_empty = 1'b1;
        for (int k = 0; k < NUM_LEVELS; k++) begin
            if (n_fill[k] != '0) begin
                w_n_empty = 1'b0;
            end
        end
    end

    // A push writes the memory in the cycle it is accepted and a following pop
    // reads it in a later cycle, so the memory never sees a read and a write
    // of the same slot together and needs no forwarding path.
    mpeq_slot_ram #(
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_wr_en (w_ram_wr),
        .i_rd_en (w_ram_rd),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    // Expiry: the 32-bit stamp plus lifetime wraps, then an unsigned compare.
    assign w_limit = w_ram_rdata.stamp + w_ram_rdata.lifetime;

    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (w_accept && (w_cmd != CMD_POP || !w_pop_found)) begin
            n_out               = '0;
            n_out.push_accepted = (w_cmd == CMD_PUSH) && w_ram_wr;
            n_out.all_empty     = w_n_empty;
            n_out_valid         = 1'b1;
        end else if (r_state == ST_READ) begin
            n_out               = '0;
            n_out.item_valid    = 1'b1;
            n_out.item_expired  = (w_ram_rdata.lifetime != '0) && (r_now > w_limit);
            n_out.item_payload  = w_ram_rdata.payload;
            n_out.item_level    = LEVEL_W'(r_pop_lv);
            n_out.all_empty     = r_pop_empty;
            n_out_valid         = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_LEVELS; k++) begin
                r_head[k] <= '0;
                r_tail[k] <= '0;
                r_fill[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_accept) begin
            r_now       <= w_now;
            r_pop_lv    <= w_pop_lv;
            r_pop_empty <= w_n_empty;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.item_valid;
    assign o_m_axis_tdata  = {2'b00, r_out.all_empty, r_out.item_level, r_out.item_payload,
                              r_out.item_expired, r_out.push_accepted};

    always_comb begin
        w_fill_over = 1'b0;
        for (int k = 0; k < NUM_LEVELS; k++) begin
            if (r_fill[k] > CW'(FIFO_DEPTH)) begin
                w_fill_over = 1'b1;
            end
        end
    end

    `MPEQ_ASSERT_NOW(a_fill_bound, 1'b1, !w_fill_over, "fill count above FIFO depth")
    `MPEQ_ASSERT_NOW(a_read_blocks_input, r_state == ST_READ, !o_s_axis_tready,
                     "input taken while a pop read is pending")
    `MPEQ_ASSERT_NEXT(a_read_yields_result, r_state == ST_READ,
                      r_out_valid && r_out.item_valid, "pop read did not produce an item")
    `MPEQ_ASSERT_NOW(a_expired_needs_item, r_out_valid && r_out.item_expired,
                     r_out.item_valid && !r_out.push_accepted,
                     "expired flag without a popped item")

endmodule

`default_nettype wire

// ===== sv/mpeq_slot_ram.sv =====
`default_nettype none

module mpeq_slot_ram
    import mpeq_pkg::*;
#(
    parameter int DEPTH = NUM_LEVELS_DEF * FIFO_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_addr,
    input  wire t_slot         i_wdata,
    output t_slot              o_rdata
);

    t_slot r_mem [DEPTH];

    // Single port: one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_rd_en) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

// ===== test/tb_multi_priority_event_queue.sv =====
module tb_multi_priority_event_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import mpeq_pkg::*;

    localparam int NUM_LEVELS = NUM_LEVELS_DEF;
    localparam int FIFO_DEPTH = FIFO_DEPTH_DEF;
    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1750;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_LIMIT = 10;

    // Command value three is not decoded by the queue and must act as a no-op.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    // tdata, lowest bit up: priority_req[7:0], time_to_live[31:0], payload[63:0], now_ms[31:0]
    logic [135:0] i_s_axis_tdata = '0;
    // tuser: command[1:0]
    logic [1:0]   i_s_axis_tuser = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    // tdata, lowest bit up: push_accepted, item_expired, item_payload[63:0],
    // item_level[2:0], all_empty, two zero pad bits
    logic [71:0]  o_m_axis_tdata;
    // tuser: item_valid
    logic         o_m_axis_tuser;

    multi_priority_event_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow copy of the queue contents, kept in step with accepted commands.
    logic [63:0] shadow_payload [NUM_LEVELS][FIFO_DEPTH];
    logic [31:0] shadow_stamp [NUM_LEVELS][FIFO_DEPTH];
    logic [31:0] shadow_lifetime [NUM_LEVELS][FIFO_DEPTH];
    int          shadow_head [NUM_LEVELS];
    int          shadow_tail [NUM_LEVELS];
    int          shadow_fill [NUM_LEVELS];

    t_result     pending_results [$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          random_items = 0;
    logic [31:0] clock_ms = 32'd0;

    initial begin
        for (int lv = 0; lv < NUM_LEVELS; lv++) begin
            shadow_head[lv] = 0;
            shadow_tail[lv] = 0;
            shadow_fill[lv] = 0;
        end
    end

    // Works out the single result a command produces and updates the shadow queues.
    function automatic t_result predict_queue_outcome(input logic [1:0] cmd,
            input logic [7:0] prio, input logic [31:0] ttl, input logic [63:0] word,
            input logic [31:0] now);
        t_result     res;
        int          lv;
        int          pos;
        bit          found;
        logic [31:0] deadline;
        res = '0;
        found = 1'b0;
        if (cmd == CMD_PUSH) begin
            lv = (prio >= NUM_LEVELS) ? NUM_LEVELS - 1 : int'(prio);
            if (shadow_fill[lv] < FIFO_DEPTH) begin
                pos = shadow_tail[lv];
                shadow_payload[lv][pos] = word;
                shadow_stamp[lv][pos] = now;
                shadow_lifetime[lv][pos] = ttl;
                shadow_tail[lv] = (pos + 1 >= FIFO_DEPTH) ? 0 : pos + 1;
                shadow_fill[lv]++;
                res.push_accepted = 1'b1;
            end
        end else if (cmd == CMD_POP) begin
            for (lv = NUM_LEVELS - 1; lv >= 0; lv--) begin
                if (!found && shadow_fill[lv] != 0) begin
                    found = 1'b1;
                    pos = shadow_head[lv];
                    res.item_valid = 1'b1;
                    res.item_payload = shadow_payload[lv][pos];
                    res.item_level = lv[LEVEL_W-1:0];
                    // A zero lifetime never expires; the deadline wraps at 32 bits.
                    if (shadow_lifetime[lv][pos] != 32'd0) begin
                        deadline = shadow_stamp[lv][pos] + shadow_lifetime[lv][pos];
                        res.item_expired = (now > deadline);
                    end
                    shadow_head[lv] = (pos + 1 >= FIFO_DEPTH) ? 0 : pos + 1;
                    shadow_fill[lv]--;
                end
            end
        end else if (cmd == CMD_CLEAR) begin
            for (lv = 0; lv < NUM_LEVELS; lv++) begin
                shadow_head[lv] = 0;
                shadow_tail[lv] = 0;
                shadow_fill[lv] = 0;
            end
        end
        res.all_empty = 1'b1;
        for (lv = 0; lv < NUM_LEVELS; lv++) begin
            if (shadow_fill[lv] != 0) res.all_empty = 1'b0;
        end
        return res;
    endfunction

    // Presents one command and holds it until the transfer happens. The sender
    // works in bursts; a gap of random length, possibly none, opens before each new burst.
    task automatic send_command(input logic [1:0] cmd, input logic [7:0] prio,
            input logic [31:0] ttl, input logic [63:0] word, input logic [31:0] now);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= cmd;
        i_s_axis_tdata <= {now, word, ttl, prio};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(predict_queue_outcome(cmd, prio, ttl, word, now));
        burst_left--;
    endtask

    task automatic report_mismatch(input string name, input logic [63:0] want,
            input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch at cycle %0d on %s: expected %h, got %h",
                     cycle_count, name, want, got);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
            input logic [63:0] got);
        if (want !== got) report_mismatch(name, want, got);
    endtask

    // Result checker: each result transfer is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing outstanding", '0,
                                64'(o_m_axis_tdata[65:2]));
            end else begin
                want = pending_results.pop_front();
                check_field("push_accepted", 64'(want.push_accepted), 64'(o_m_axis_tdata[0]));
                check_field("item_expired", 64'(want.item_expired), 64'(o_m_axis_tdata[1]));
                check_field("item_payload", want.item_payload, o_m_axis_tdata[65:2]);
                check_field("item_level", 64'(want.item_level), 64'(o_m_axis_tdata[68:66]));
                check_field("all_empty", 64'(want.all_empty), 64'(o_m_axis_tdata[69]));
                check_field("pad bits", 64'd0, 64'(o_m_axis_tdata[71:70]));
                check_field("item_valid", 64'(want.item_valid), 64'(o_m_axis_tuser));
            end
        end
    end

    // Receiver backpressure: a mode is held for a while, then another is drawn.
    int stall_mode = 0;
    int mode_left = 0;
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: i_m_axis_tready <= 1'($urandom_range(0, 1));
            default: i_m_axis_tready <= ((cycle_count % 9) < 5);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] pick_lifetime();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25) return 32'd0;
        if (roll < 75) return 32'($urandom_range(1, 60));
        if (roll < 90) return $urandom;
        return 32'hFFFF_FFFF;
    endfunction

    // Time mostly moves forward in small steps, so lifetimes end within reach;
    // now and then it jumps near the wrap point or takes a stray value.
    function automatic logic [31:0] pick_now();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) return $urandom;
        if (roll < 5) clock_ms = 32'hFFFF_FF80 + 32'($urandom_range(0, 127));
        clock_ms = clock_ms + 32'($urandom_range(0, 12));
        return clock_ms;
    endfunction

    function automatic logic [7:0] pick_priority();
        if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, NUM_LEVELS - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic test_empty_and_unused();
        send_command(CMD_POP, 8'hFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_command(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                     32'hFFFF_FFFF);
    endtask

    // Pops must come out from the highest level first. Expiry is probed with a
    // lifetime that never ends, a deadline sum that wraps, and a plain timeout.
    task automatic test_level_order_and_expiry();
        send_command(CMD_PUSH, 8'd0, 32'd0, 64'd0, 32'd0);
        send_command(CMD_PUSH, 8'hFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_command(CMD_PUSH, 8'd1, 32'd1, 64'hA5A5_5A5A_0F0F_F0F0, 32'hFFFF_FFFF);
        send_command(CMD_PUSH, 8'd2, 32'd5, 64'h0123_4567_89AB_CDEF, 32'd100);
        send_command(CMD_POP, 8'd0, 32'd0, 64'd0, 32'd0);
        send_command(CMD_POP, 8'd0, 32'd0, 64'd0, 32'd106);
        send_command(CMD_POP, 8'd0, 32'd0, 64'd0, 32'hFFFF_FFFF);
        send_command(CMD_POP, 8'd0, 32'd0, 64'd0, 32'hFFFF_FFFF);
        send_command(CMD_POP, 8'd0, 32'd0, 64'd0, 32'd0);
    endtask

    task automatic test_clear();
        send_command(CMD_PUSH, 8'd0, 32'd7, 64'h1111_2222_3333_4444, 32'd10);
        send_command(CMD_PUSH, 8'd2, 32'd0, 64'h5555_6666_7777_8888, 32'd11);
        send_command(CMD_CLEAR, 8'hFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd12);
        send_command(CMD_POP, 8'd0, 32'd0, 64'd0, 32'd13);
        send_command(CMD_PUSH, 8'd1, 32'd3, 64'h9999_AAAA_BBBB_CCCC, 32'd14);
        send_command(CMD_POP, 8'd0, 32'd0, 64'd0, 32'd20);
    endtask

    // Random traffic built from sequences: mixed commands, bursts that fill one
    // level, possibly past full, long drains, clears, and a little unconstrained noise.
    task automatic test_random_traffic(input int item_target);
        int          kind;
        int          count;
        int          roll;
        logic [7:0]  lvl;
        logic [1:0]  cmd;
        while (random_items < item_target) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                count = $urandom_range(5, 30);
                repeat (count) begin
                    roll = $urandom_range(0, 99);
                    cmd = (roll < 48) ? CMD_PUSH : (roll < 92) ? CMD_POP
                        : (roll < 96) ? CMD_CLEAR : CMD_UNUSED;
                    send_command(cmd, pick_priority(), pick_lifetime(),
                                 {$urandom, $urandom}, pick_now());
                    if (cmd != CMD_UNUSED) random_items++;
                end
            end else if (kind < 62) begin
                lvl = 8'($urandom_range(0, NUM_LEVELS - 1));
                count = $urandom_range(12, FIFO_DEPTH + 4);
                repeat (count) begin
                    send_command(CMD_PUSH,
                                 (lvl == NUM_LEVELS - 1) ? 8'($urandom_range(lvl, 255)) : lvl,
                                 pick_lifetime(), {$urandom, $urandom}, pick_now());
                    random_items++;
                end
            end else if (kind < 84) begin
                count = $urandom_range(5, 40);
                repeat (count) begin
                    send_command(CMD_POP, 8'($urandom), $urandom, {$urandom, $urandom},
                                 pick_now());
                    random_items++;
                end
            end else if (kind < 89) begin
                send_command(CMD_CLEAR, 8'($urandom), $urandom, {$urandom, $urandom},
                             pick_now());
                random_items++;
            end else begin
                repeat (10) begin
                    cmd = 2'($urandom_range(0, 3));
                    send_command(cmd, 8'($urandom), $urandom, {$urandom, $urandom}, $urandom);
                    if (cmd != CMD_UNUSED) random_items++;
                end
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_and_unused();
        test_level_order_and_expiry();
        test_clear();
        test_random_traffic(RANDOM_ITEMS);
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/mpeq_pkg.sv
sv/mpeq_slot_ram.sv
sv/multi_priority_event_queue.sv
test/tb_multi_priority_event_queue.sv
